/* hw/rtl/two_wheel_balance_controller_core_defines.svh */
// Assertion macros for the two-wheel balance controller.
`ifndef TWO_WHEEL_BALANCE_CONTROLLER_CORE_DEFINES_SVH
`define TWO_WHEEL_BALANCE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define TWBC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TWBC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/twbc_pkg.sv */
// Shared types and constants of the two-wheel balance controller.
`timescale 1ns / 1ps

package twbc_pkg;

   // register indexes
   typedef enum logic [2:0] {
      REG_KP_BALANCE     = 3'd0,
      REG_KD_BALANCE     = 3'd1,
      REG_BALANCE_LIMIT  = 3'd2,
      REG_KP_VELOCITY    = 3'd3,
      REG_KI_VELOCITY    = 3'd4,
      REG_INTEGRAL_LIMIT = 3'd5,
      REG_KP_TURN        = 3'd6,
      REG_DRIVE_LIMIT    = 3'd7
   } csr_reg_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] KP_BALANCE_RST     = 16'd5734;
   localparam logic [15:0] KD_BALANCE_RST     = 16'd215;
   localparam logic [14:0] BALANCE_LIMIT_RST  = 15'd400;
   localparam logic [15:0] KP_VELOCITY_RST    = 16'd9984;
   localparam logic [15:0] KI_VELOCITY_RST    = 16'd20;
   localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'd10000;
   localparam logic [15:0] KP_TURN_RST        = 16'd1024;
   localparam logic [9:0]  DRIVE_LIMIT_RST    = 10'd500;

   // shared multiplier: signed A x signed B
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 31;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 44;
   localparam int QUO_W   = ACC_W - 16;

   // ceil(2^32/5), ceil(2^32/10): exact for the operand ranges used here
   localparam logic [MUL_B_W-1:0] RECIP5  = 31'd858993460;
   localparam logic [MUL_B_W-1:0] RECIP10 = 31'd429496730;

   // Q8.8 angle thresholds, Q12.8 rate threshold
   localparam logic signed [15:0] FALL_ANGLE    = 16'sd10240;
   localparam logic signed [15:0] UPRIGHT_ANGLE = 16'sd3840;
   localparam logic signed [19:0] UPRIGHT_RATE  = 20'sd768;

   typedef struct packed {
      logic signed [15:0] tilt_angle;
      logic signed [19:0] pitch_rate;
      logic signed [19:0] yaw_rate;
      logic signed [15:0] count_left;
      logic signed [15:0] count_right;
   } req_type;

   typedef struct packed {
      logic [9:0] left_fwd_duty;
      logic [9:0] left_rev_duty;
      logic [9:0] right_fwd_duty;
      logic [9:0] right_rev_duty;
      logic       running;
   } rsp_type;

endpackage

/* hw/rtl/two_wheel_balance_controller_core.sv */
// Top level of the two-wheel balance controller: sequencer, state and I/O.
`timescale 1ns / 1ps
`include "two_wheel_balance_controller_core_defines.svh"

// One item is one control tick: tilt angle, pitch rate, yaw rate and both
// wheel encoder counts. Each item gives exactly one result: four PWM duties
// and the running flag. While waiting for upright the result is loaded in
// the cycle the item is taken. A running tick walks a 13-step
// sequencer around one shared 28x31 signed multiplier (balance PD, speed
// filter /5 and integral /10 by reciprocal multiply, velocity PI, turn P,
// then mixing) and registers its result in ST_MIX, the last step, which
// holds while the output register is occupied. The multiplier is the only
// multiply resource and is used at most once per step. The result sits in
// an output register; a new item is taken when the sequencer is idle and
// that register is free or is being drained in the same cycle. req_stall
// is high while a tick is in progress. Gains and limits are written
// through the csr port (always ready) and are expected to change only
// while no tick is in flight.
module two_wheel_balance_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  twbc_pkg::req_type                 req_data,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output twbc_pkg::rsp_type                 rsp_data,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [twbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [twbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = twbc_pkg::MUL_A_W;
   localparam int BW = twbc_pkg::MUL_B_W;
   localparam int PW = twbc_pkg::PROD_W;
   localparam int CW = twbc_pkg::ACC_W;
   localparam int QW = twbc_pkg::QUO_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B0,   // angle * kp
      ST_B1,   // rate * kd
      ST_B2,   // sum balance; speed filter numerator * 1/5
      ST_B3,   // clamp balance; new filtered speed
      ST_F1,   // |speed| * 1/10
      ST_I0,   // integral update and clamp
      ST_V0,   // speed * kp_v
      ST_V1,   // integral * ki
      ST_V2,   // sum velocity
      ST_V3,   // velocity term; yaw * kp_t
      ST_T0,
      ST_T1,   // turn term
      ST_MIX   // mixing, duties, fall check
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] kp_balance_ff, kd_balance_ff, kp_velocity_ff, ki_velocity_ff, kp_turn_ff;
   logic [14:0] balance_limit_ff, integral_limit_ff;
   logic [9:0]  drive_limit_ff;

   // controller state
   logic signed [25:0] fs_ff;    // filtered speed, Q17.8
   logic signed [25:0] si_ff;    // speed integral, Q17.8
   logic               run_mode_ff;

   // per-tick working registers
   twbc_pkg::req_type  in_ff;
   logic signed [CW-1:0] acc_ff;
   logic signed [15:0] b_ff, v_ff, t_ff;
   logic               x_neg_ff, fs_neg_ff;

   logic               rsp_valid_ff;
   twbc_pkg::rsp_type  rsp_data_ff;

   // multiplier
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod_ff;

   // datapath
   logic               out_free;
   logic               accept;
   logic               rsp_load;
   logic               upright;
   logic signed [16:0] csum;
   logic signed [27:0] x_val;
   logic [27:0]        x_mag;
   logic [25:0]        fs_mag;
   logic [24:0]        q5;
   logic [25:0]        q10;
   logic signed [25:0] fs_new;
   logic signed [25:0] d10;
   logic signed [26:0] si_sum;
   logic signed [26:0] si_lim;
   logic signed [25:0] si_new;
   logic signed [QW-1:0] b_quo;
   logic signed [QW-1:0] b_lim;
   logic signed [15:0] b_new;
   logic signed [17:0] mix_l, mix_r;
   logic signed [15:0] cmd_l, cmd_r;
   logic [19:0]        duty_l, duty_r;
   logic               fall;

   // truncating divide by 65536
   function automatic logic signed [QW-1:0] tdiv(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] adj;
      adj = v + (v[CW-1] ? CW'(65535) : CW'(0));
      return adj[CW-1:16];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] v);
      if (v > QW'(32767)) begin
         return 16'sh7FFF;
      end else if (v < -QW'(32768)) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // {fwd, rev}: sign picks the side, magnitude clamped to lim
   function automatic logic [19:0] drive(input logic signed [15:0] cmd,
                                         input logic [9:0] lim);
      logic [16:0] mag;
      logic [9:0]  d;
      mag = cmd[15] ? 17'(-$signed({cmd[15], cmd})) : {1'b0, cmd};
      d = (mag > {7'b0, lim}) ? lim : mag[9:0];
      return cmd[15] ? {10'b0, d} : {d, 10'b0};
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register loads: waiting tick when taken, running tick at the end
   assign rsp_load  = (accept && !run_mode_ff) || ((state_ff == ST_MIX) && out_free);

   assign upright = (req_data.tilt_angle < twbc_pkg::UPRIGHT_ANGLE) &&
                    (req_data.tilt_angle > -twbc_pkg::UPRIGHT_ANGLE) &&
                    (req_data.pitch_rate < twbc_pkg::UPRIGHT_RATE) &&
                    (req_data.pitch_rate > -twbc_pkg::UPRIGHT_RATE);

   // speed filter numerator: 4*fs + 256*(cl + cr)
   always_comb begin
      csum  = 17'(in_ff.count_left) + 17'(in_ff.count_right);
      x_val = $signed({{2{fs_ff[25]}}, fs_ff} <<< 2) + $signed({{3{csum[16]}}, csum, 8'b0});
      x_mag = x_val[27] ? 28'(-x_val) : x_val;
      fs_mag = fs_ff[25] ? 26'(-fs_ff) : fs_ff;
      q5    = prod_ff[56:32];
      q10   = prod_ff[57:32];
      fs_new = x_neg_ff ? -$signed({1'b0, q5}) : $signed({1'b0, q5});
      d10   = fs_neg_ff ? -$signed(q10) : $signed(q10);
      si_sum = 27'(si_ff) + 27'(d10);
      si_lim = $signed({4'b0, integral_limit_ff, 8'b0});
      if (si_sum > si_lim) begin
         si_new = si_lim[25:0];
      end else if (si_sum < -si_lim) begin
         si_new = 26'(-si_lim);
      end else begin
         si_new = si_sum[25:0];
      end
   end

   // balance clamp
   always_comb begin
      b_quo = tdiv(acc_ff);
      b_lim = $signed({{(QW-15){1'b0}}, balance_limit_ff});
      if (b_quo > b_lim) begin
         b_new = b_lim[15:0];
      end else if (b_quo < -b_lim) begin
         b_new = 16'(-b_lim);
      end else begin
         b_new = b_quo[15:0];
      end
   end

   // mixing
   always_comb begin
      mix_l  = 18'(b_ff) + 18'(v_ff) - 18'(t_ff);
      mix_r  = 18'(b_ff) + 18'(v_ff) + 18'(t_ff);
      cmd_l  = sat16(QW'(mix_l));
      cmd_r  = sat16(QW'(mix_r));
      duty_l = drive(cmd_l, drive_limit_ff);
      duty_r = drive(cmd_r, drive_limit_ff);
      fall   = (in_ff.tilt_angle > twbc_pkg::FALL_ANGLE) ||
               (in_ff.tilt_angle < -twbc_pkg::FALL_ANGLE);
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_B0: begin
            mul_a = AW'(in_ff.tilt_angle);
            mul_b = $signed({{(BW-16){1'b0}}, kp_balance_ff});
         end
         ST_B1: begin
            mul_a = AW'(in_ff.pitch_rate);
            mul_b = $signed({{(BW-16){1'b0}}, kd_balance_ff});
         end
         ST_B2: begin
            mul_a = $signed({1'b0, x_mag[26:0]});
            mul_b = $signed(twbc_pkg::RECIP5);
         end
         ST_F1: begin
            mul_a = $signed({2'b0, fs_mag});
            mul_b = $signed(twbc_pkg::RECIP10);
         end
         ST_V0: begin
            mul_a = AW'(fs_ff);
            mul_b = $signed({{(BW-16){1'b0}}, kp_velocity_ff});
         end
         ST_V1: begin
            mul_a = AW'(si_ff);
            mul_b = $signed({{(BW-16){1'b0}}, ki_velocity_ff});
         end
         ST_V3: begin
            mul_a = AW'(in_ff.yaw_rate);
            mul_b = $signed({{(BW-16){1'b0}}, kp_turn_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   twbc_mul #(
      .A_W (AW),
      .B_W (BW)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         run_mode_ff       <= 1'b0;
         fs_ff             <= '0;
         si_ff             <= '0;
         kp_balance_ff     <= twbc_pkg::KP_BALANCE_RST;
         kd_balance_ff     <= twbc_pkg::KD_BALANCE_RST;
         balance_limit_ff  <= twbc_pkg::BALANCE_LIMIT_RST;
         kp_velocity_ff    <= twbc_pkg::KP_VELOCITY_RST;
         ki_velocity_ff    <= twbc_pkg::KI_VELOCITY_RST;
         integral_limit_ff <= twbc_pkg::INTEGRAL_LIMIT_RST;
         kp_turn_ff        <= twbc_pkg::KP_TURN_RST;
         drive_limit_ff    <= twbc_pkg::DRIVE_LIMIT_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               twbc_pkg::REG_KP_BALANCE:     kp_balance_ff     <= csr_wdata;
               twbc_pkg::REG_KD_BALANCE:     kd_balance_ff     <= csr_wdata;
               twbc_pkg::REG_BALANCE_LIMIT:  balance_limit_ff  <= csr_wdata[14:0];
               twbc_pkg::REG_KP_VELOCITY:    kp_velocity_ff    <= csr_wdata;
               twbc_pkg::REG_KI_VELOCITY:    ki_velocity_ff    <= csr_wdata;
               twbc_pkg::REG_INTEGRAL_LIMIT: integral_limit_ff <= csr_wdata[14:0];
               twbc_pkg::REG_KP_TURN:        kp_turn_ff        <= csr_wdata;
               twbc_pkg::REG_DRIVE_LIMIT:    drive_limit_ff    <= csr_wdata[9:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  in_ff <= req_data;
                  if (run_mode_ff) begin
                     state_ff <= ST_B0;
                  end else begin
                     // waiting: zero drive, maybe wake up
                     rsp_data_ff  <= '{default: '0, running: upright};
                     run_mode_ff  <= upright;
                  end
               end
            end
            ST_B0: state_ff <= ST_B1;
            ST_B1: begin
               acc_ff   <= prod_ff[CW-1:0];
               state_ff <= ST_B2;
            end
            ST_B2: begin
               acc_ff   <= acc_ff + prod_ff[CW-1:0];
               x_neg_ff <= x_val[27];
               state_ff <= ST_B3;
            end
            ST_B3: begin
               b_ff     <= b_new;
               fs_ff    <= fs_new;
               state_ff <= ST_F1;
            end
            ST_F1: begin
               fs_neg_ff <= fs_ff[25];
               state_ff  <= ST_I0;
            end
            ST_I0: begin
               si_ff    <= si_new;
               state_ff <= ST_V0;
            end
            ST_V0: state_ff <= ST_V1;
            ST_V1: begin
               acc_ff   <= prod_ff[CW-1:0];
               state_ff <= ST_V2;
            end
            ST_V2: begin
               acc_ff   <= acc_ff + prod_ff[CW-1:0];
               state_ff <= ST_V3;
            end
            ST_V3: begin
               v_ff     <= sat16(tdiv(acc_ff));
               state_ff <= ST_T0;
            end
            ST_T0: begin
               acc_ff   <= prod_ff[CW-1:0];
               state_ff <= ST_T1;
            end
            ST_T1: begin
               t_ff     <= sat16(tdiv(acc_ff));
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               // hold here until the output register can take the result
               if (out_free) begin
                  rsp_data_ff  <= '{left_fwd_duty:  duty_l[19:10],
                                    left_rev_duty:  duty_l[9:0],
                                    right_fwd_duty: duty_r[19:10],
                                    right_rev_duty: duty_r[9:0],
                                    running:        !fall};
                  if (fall) begin
                     run_mode_ff <= 1'b0;
                     si_ff       <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // at most one duty per side is nonzero
   `TWBC_ASSERT_IMP(a_side_exclusive, clock, reset, rsp_valid_ff,
      (rsp_data_ff.left_fwd_duty == '0 || rsp_data_ff.left_rev_duty == '0) &&
      (rsp_data_ff.right_fwd_duty == '0 || rsp_data_ff.right_rev_duty == '0),
      "both duties of one side active")
   // duties never exceed the drive limit
   `TWBC_ASSERT_IMP(a_duty_limit, clock, reset, rsp_valid_ff,
      (rsp_data_ff.left_fwd_duty <= drive_limit_ff) &&
      (rsp_data_ff.left_rev_duty <= drive_limit_ff) &&
      (rsp_data_ff.right_fwd_duty <= drive_limit_ff) &&
      (rsp_data_ff.right_rev_duty <= drive_limit_ff), "duty above drive limit")
   // integral is empty whenever the controller is waiting
   `TWBC_ASSERT_IMP(a_wait_integral, clock, reset, !run_mode_ff, si_ff == '0,
      "integral not cleared while waiting")
   // a waiting tick answers on the next cycle
   `TWBC_ASSERT_NXT(a_wait_latency, clock, reset, accept && !run_mode_ff, rsp_valid_ff,
      "waiting tick gave no result")

endmodule

/* hw/rtl/twbc_mul.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module twbc_mul #(
   parameter int A_W = twbc_pkg::MUL_A_W,
   parameter int B_W = twbc_pkg::MUL_B_W
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      op_a,
   input  logic signed [B_W-1:0]      op_b,
   output logic signed [A_W+B_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule
